>>> hw/rtl/ulpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulpr_pkg
// Shared types and codes for the double-buffered serial line receiver.
// ----------------------------------------------------------------------------
package ulpr_pkg;

  localparam int LINE_DEPTH_DEF = 64;

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_FIRST  = 2'd1;
  localparam logic [1:0] ACT_SECOND = 2'd2;

  localparam logic [1:0] DONE_NONE   = 2'd0;
  localparam logic [1:0] DONE_FIRST  = 2'd1;
  localparam logic [1:0] DONE_SECOND = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic       rx_error;
    logic       store_sel;
    logic [5:0] read_index;
  } ulpr_in_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic       ready_first;
    logic       ready_second;
    logic [1:0] line_done;
    logic       discarding;
  } ulpr_out_t;

  // status carried alongside the memory read
  typedef struct packed {
    logic       ready_first;
    logic       ready_second;
    logic [1:0] line_done;
    logic       discarding;
  } ulpr_flags_t;

endpackage

>>> hw/rtl/uart_line_pingpong_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_line_pingpong_receiver_unit
// Assembles CR-terminated lines into two alternating line stores held in one
// synchronous memory; the consumer reads characters and releases stores.
// ----------------------------------------------------------------------------
// A result beat passes the registered memory read, then the output register.
// Throughput: one request per cycle unless the output is blocked; each memory
// access is a single write or a single read done at the accept edge, so
// accesses never overlap.
// Reset clears write position, active store, ready flags and discard mode;
// the line stores are not cleared and need no clearing pass.
module uart_line_pingpong_receiver_unit
  import ulpr_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  ulpr_in_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output ulpr_out_t rsp
);

  localparam int PosW = $clog2(LINE_DEPTH);
  localparam int CntW = $clog2(LINE_DEPTH + 1);
  localparam int CmpW = (CntW > 6) ? CntW : 6;

  // line store memory: upper address bit picks the store
  logic [7:0] mem [2**(PosW+1)];
  logic [7:0] rdata;

  // control state
  logic [CntW-1:0] write_pos, write_pos_next;
  logic [1:0]      active, active_next;
  logic            first_ready, first_ready_next;
  logic            second_ready, second_ready_next;
  logic            discard, discard_next;
  logic [1:0]      done;

  // pipeline
  logic        s1_valid;
  logic        s1_rd;
  ulpr_flags_t s1_flags;
  ulpr_out_t   out_q;
  logic        accept;
  logic        s1_move;

  logic            we;
  logic [7:0]      wdata;
  logic [PosW:0]   waddr;
  logic            re;
  logic [PosW:0]   raddr;
  logic [CmpW-1:0] idx_ext;
  logic            idx_ok;
  logic            act_first;
  logic            act_second;

  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign act_first  = (active == ACT_FIRST);
  assign act_second = (active == ACT_SECOND);

  assign idx_ext = CmpW'(req.read_index);
  assign idx_ok  = idx_ext < CmpW'(LINE_DEPTH);
  assign raddr   = {req.store_sel, idx_ext[PosW-1:0]};
  assign waddr   = {act_second, write_pos[PosW-1:0]};

  always_comb begin
    write_pos_next    = write_pos;
    active_next       = active;
    first_ready_next  = first_ready;
    second_ready_next = second_ready;
    discard_next      = discard;
    done              = DONE_NONE;
    we                = 1'b0;
    wdata             = req.rx_byte;
    re                = 1'b0;
    unique case (req.op)
      OP_BYTE: begin
        if (req.rx_error) begin
          discard_next = 1'b1;
        end else if (req.rx_byte == CH_LF) begin
          // line feeds are dropped silently
        end else if (discard) begin
          if (req.rx_byte == CH_CR) begin
            discard_next   = 1'b0;
            write_pos_next = '0;
          end
        end else if (!act_first && !act_second) begin
          discard_next = 1'b1;
        end else if (write_pos >= CntW'(LINE_DEPTH)) begin
          discard_next = 1'b1;
        end else if (req.rx_byte == CH_CR) begin
          we             = 1'b1;
          wdata          = '0;
          write_pos_next = '0;
          if (act_first) begin
            first_ready_next = 1'b1;
            active_next      = second_ready ? ACT_NONE : ACT_SECOND;
            done             = DONE_FIRST;
          end else begin
            second_ready_next = 1'b1;
            active_next       = first_ready ? ACT_NONE : ACT_FIRST;
            done              = DONE_SECOND;
          end
        end else begin
          we             = 1'b1;
          write_pos_next = write_pos + CntW'(1);
          // last position taken: line too long
          if (write_pos == CntW'(LINE_DEPTH - 1)) begin
            discard_next = 1'b1;
          end
        end
      end
      OP_READ: begin
        re = idx_ok;
      end
      OP_RELEASE: begin
        if (req.store_sel) begin
          second_ready_next = 1'b0;
        end else begin
          first_ready_next = 1'b0;
        end
        if (!act_first && !act_second) begin
          active_next = req.store_sel ? ACT_SECOND : ACT_FIRST;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos    <= '0;
      active       <= ACT_FIRST;
      first_ready  <= 1'b0;
      second_ready <= 1'b0;
      discard      <= 1'b0;
    end else if (accept) begin
      write_pos    <= write_pos_next;
      active       <= active_next;
      first_ready  <= first_ready_next;
      second_ready <= second_ready_next;
      discard      <= discard_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      s1_valid  <= accept || (s1_valid && !s1_move);
      rsp_valid <= s1_move || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd                 <= re;
      s1_flags.ready_first  <= first_ready_next;
      s1_flags.ready_second <= second_ready_next;
      s1_flags.line_done    <= done;
      s1_flags.discarding   <= discard_next;
    end
    if (s1_move) begin
      out_q.read_char    <= s1_rd ? rdata : 8'h00;
      out_q.ready_first  <= s1_flags.ready_first;
      out_q.ready_second <= s1_flags.ready_second;
      out_q.line_done    <= s1_flags.line_done;
      out_q.discarding   <= s1_flags.discarding;
    end
  end

  assign rsp = out_q;

  // a finished line must show its ready flag in the same beat
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1_flags.line_done == DONE_FIRST) |-> s1_flags.ready_first)
    else $error("first store completed without ready flag");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1_flags.line_done == DONE_SECOND) |-> s1_flags.ready_second)
    else $error("second store completed without ready flag");

  // with both stores full no store may be taking characters
  assert property (@(posedge clk) disable iff (rst)
    first_ready && second_ready |-> (active == ACT_NONE))
    else $error("store active while both stores hold lines");

  // outside discard mode the write position stays inside the store
  assert property (@(posedge clk) disable iff (rst)
    !discard |-> (write_pos < CntW'(LINE_DEPTH)))
    else $error("write position past end of store");

  // a waiting middle beat is held while the output is blocked
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp_valid && rsp_stall |=>
      s1_valid && $stable(s1_flags) && (!s1_rd || $stable(rdata)))
    else $error("middle beat lost while output stalled");

endmodule
